### rtl/char_stack_with_occurrence_count_assert.svh
// Assertion macros shared by the character stack RTL.
`ifndef CHAR_STACK_WITH_OCCURRENCE_COUNT_ASSERT_SVH
`define CHAR_STACK_WITH_OCCURRENCE_COUNT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CSOC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csoc assertion failed");

// next-cycle implication, checked out of reset
`define CSOC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csoc assertion failed");

`endif

### rtl/csoc_pkg.sv
// Package: sizes, command and status codes, shared types of the character stack.
package csoc_pkg;

  localparam int DEPTH   = 128;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DEPTH_W = $clog2(DEPTH + 1);
  localparam int BYTE_W  = 8;
  localparam int CAP_W   = 8;
  localparam int CNT_W   = 8;
  localparam int CMP_W   = (DEPTH_W > CAP_W) ? DEPTH_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_COUNT = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_LOWER = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7a;

  typedef struct packed {
    logic clear;
    logic accum;
  } csoc_match_ctl_t;

endpackage

### rtl/csoc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module csoc_ram #(
  parameter int W = 8,
  parameter int D = 128
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                         wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/csoc_match.sv
// Shared byte compare unit with saturating match accumulator.
module csoc_match (
  input  logic                             clk,
  input  csoc_pkg::csoc_match_ctl_t        ctl,
  input  logic [csoc_pkg::BYTE_W-1:0]      key,
  input  logic [csoc_pkg::BYTE_W-1:0]      data,
  output logic                             eq,
  output logic [csoc_pkg::CNT_W-1:0]       count
);

  import csoc_pkg::*;

  assign eq = (data == key);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      count <= '0;
    end else if (ctl.accum && eq && (count != {CNT_W{1'b1}})) begin
      count <= count + CNT_W'(1);
    end
  end

endmodule

### rtl/char_stack_with_occurrence_count.sv
// Top level: bounded LIFO stack of lowercase letters with occurrence count.
// Pushes that fail a check (full, not a letter), pushes onto an empty stack,
// pops of an empty stack, counts of an empty stack and unused commands finish
// in the idle state; a push or pop on a non-empty stack waits for the
// registered read of the top entry; a count walks the stack, as the
// single read port of the stack memory feeds one entry a cycle to the shared
// compare unit. Each result word lands in an output register; the input
// stalls while an item is in work, and an item whose result finds that
// register still occupied waits in S_EMIT until it frees. The stack memory
// needs no clearing pass after reset. The capacity register is always ready.
`include "char_stack_with_occurrence_count_assert.svh"

module char_stack_with_occurrence_count (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        command,
  input  logic [csoc_pkg::BYTE_W-1:0]       item_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        status,
  output logic [csoc_pkg::BYTE_W-1:0]       popped_byte,
  output logic [csoc_pkg::CNT_W-1:0]        match_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [csoc_pkg::CAP_W-1:0]        capacity_in_use
);

  import csoc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_POP,
    S_COUNT,
    S_EMIT
  } state_t;

  state_t              state, state_next;
  logic [DEPTH_W-1:0]  depth;
  logic [DEPTH_W-1:0]  depth_m1;
  logic [DEPTH_W-1:0]  idx;
  logic [CAP_W-1:0]    capacity;
  logic [BYTE_W-1:0]   key;
  logic                rd_pending;

  logic [2:0]          res_status;
  logic [BYTE_W-1:0]   res_popped;
  logic [CNT_W-1:0]    res_count;

  logic                accept, out_free, full, lower, count_issue;
  logic                fin;
  logic [2:0]          fin_status;
  logic [BYTE_W-1:0]   fin_popped;
  logic [CNT_W-1:0]    fin_count;

  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [BYTE_W-1:0]   wdata, rdata;

  csoc_match_ctl_t     mctl;
  logic                eq;
  logic [CNT_W-1:0]    acc_count;

  csoc_ram #(.W(BYTE_W), .D(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  csoc_match u_match (
    .clk   (clk),
    .ctl   (mctl),
    .key   (key),
    .data  (rdata),
    .eq    (eq),
    .count (acc_count)
  );

  assign cfg_ready = 1'b1;

  always_comb begin
    in_stall    = (state != S_IDLE);
    accept      = in_valid && !in_stall;
    out_free    = !out_valid || !out_stall;
    full        = (CMP_W'(depth) >= CMP_W'(capacity)) || (depth == DEPTH_W'(DEPTH));
    lower       = item_byte inside {[CHAR_LOWER_A:CHAR_LOWER_Z]};
    depth_m1    = depth - DEPTH_W'(1);
    count_issue = (state == S_COUNT) && (idx < depth);
    raddr       = (state == S_COUNT) ? idx[AW-1:0] : depth_m1[AW-1:0];
    waddr       = depth[AW-1:0];
    wdata       = (state == S_IDLE) ? item_byte : key;
    mctl.clear  = accept;
    mctl.accum  = (state == S_COUNT) && rd_pending;

    we         = 1'b0;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_popped = '0;
    fin_count  = '0;
    state_next = state;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (command)
            CMD_PUSH: begin
              if (full) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
              end else if (!lower) begin
                fin        = 1'b1;
                fin_status = ST_NOT_LOWER;
              end else if (depth == '0) begin
                fin = 1'b1;
                we  = 1'b1;
              end else begin
                state_next = S_PUSH;
              end
            end
            CMD_POP: begin
              if (depth == '0) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else begin
                state_next = S_POP;
              end
            end
            CMD_COUNT: begin
              if (depth == '0) begin
                fin = 1'b1;
              end else begin
                state_next = S_COUNT;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_PUSH: begin
        fin = 1'b1;
        if (eq) begin
          fin_status = ST_DUPLICATE;
        end else begin
          we = 1'b1;
        end
      end
      S_POP: begin
        fin        = 1'b1;
        fin_popped = rdata;
      end
      S_COUNT: begin
        if (!count_issue && !rd_pending) begin
          fin       = 1'b1;
          fin_count = acc_count;
        end
      end
      S_EMIT: begin
        fin        = 1'b1;
        fin_status = res_status;
        fin_popped = res_popped;
        fin_count  = res_count;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      state_next = out_free ? S_IDLE : S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      depth      <= '0;
      idx        <= '0;
      rd_pending <= 1'b0;
      capacity   <= CAP_RESET;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        capacity <= capacity_in_use;
      end
      if (accept) begin
        key        <= item_byte;
        idx        <= '0;
        rd_pending <= 1'b0;
      end
      if (state == S_COUNT) begin
        rd_pending <= count_issue;
        if (count_issue) begin
          idx <= idx + DEPTH_W'(1);
        end
      end
      if (we) begin
        depth <= depth + DEPTH_W'(1);
      end else if (state == S_POP) begin
        depth <= depth_m1;
      end
      if (fin && out_free) begin
        out_valid   <= 1'b1;
        status      <= fin_status;
        popped_byte <= fin_popped;
        match_count <= fin_count;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (fin && !out_free) begin
        res_status <= fin_status;
        res_popped <= fin_popped;
        res_count  <= fin_count;
      end
    end
  end

  `CSOC_ASSERT_IMP(a_depth_bound, 1'b1, depth <= DEPTH_W'(DEPTH))
  `CSOC_ASSERT_IMP(a_write_in_range, we, depth < DEPTH_W'(DEPTH))
  `CSOC_ASSERT_IMP(a_walk_in_range, state == S_COUNT, idx <= depth)
  `CSOC_ASSERT_NXT(a_pop_shrinks, state == S_POP, depth == $past(depth) - DEPTH_W'(1))

endmodule

### tb/csoc_result_checker.sv
// Checker: models the character stack and compares each result word with its prediction.
module csoc_result_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic [csoc_pkg::BYTE_W-1:0] item_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [2:0]                  status,
  input  logic [csoc_pkg::BYTE_W-1:0] popped_byte,
  input  logic [csoc_pkg::CNT_W-1:0]  match_count,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [csoc_pkg::CAP_W-1:0]  capacity_in_use,
  output int                          fail_count,
  output int                          pending
);

  import csoc_pkg::*;

  typedef struct packed {
    logic [2:0]        status;
    logic [BYTE_W-1:0] popped;
    logic [CNT_W-1:0]  count;
  } stack_reply_t;

  logic [BYTE_W-1:0] stack_mem [DEPTH];
  int unsigned       stack_level;
  logic [CAP_W-1:0]  capacity;
  stack_reply_t      reply_q [$];

  function automatic stack_reply_t predict_reply(input logic [1:0] cmd,
                                                 input logic [BYTE_W-1:0] chr);
    stack_reply_t r;
    int unsigned  limit;
    int unsigned  hits;
    r = '0;
    r.status = ST_OK;
    limit = capacity;
    if (limit > DEPTH) limit = DEPTH;
    hits = 0;
    case (cmd)
      CMD_PUSH: begin
        if (stack_level >= limit) begin
          r.status = ST_FULL;
        end else if (chr < CHAR_LOWER_A || chr > CHAR_LOWER_Z) begin
          r.status = ST_NOT_LOWER;
        end else if (stack_level > 0 && stack_mem[stack_level-1] == chr) begin
          r.status = ST_DUPLICATE;
        end else begin
          stack_mem[stack_level] = chr;
          stack_level++;
        end
      end
      CMD_POP: begin
        if (stack_level == 0) begin
          r.status = ST_EMPTY;
        end else begin
          stack_level--;
          r.popped = stack_mem[stack_level];
        end
      end
      CMD_COUNT: begin
        for (int i = 0; i < stack_level; i++) begin
          if (stack_mem[i] == chr && hits < 255) hits++;
        end
        r.count = CNT_W'(hits);
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    stack_reply_t got;
    stack_reply_t want;
    if (rst) begin
      stack_level = 0;
      capacity = CAP_RESET;
      reply_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.status = status;
        got.popped = popped_byte;
        got.count = match_count;
        if (reply_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected word: status %0d popped %02h count %0d",
                     got.status, got.popped, got.count);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"mismatch: exp status %0d popped %02h count %0d, ",
                        "got status %0d popped %02h count %0d"},
                       want.status, want.popped, want.count,
                       got.status, got.popped, got.count);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) capacity = capacity_in_use;
      if (in_valid && !in_stall) reply_q.push_back(predict_reply(command, item_byte));
    end
    pending = reply_q.size();
  end

endmodule

### tb/char_stack_with_occurrence_count_tb.sv
// Testbench top: drives the character stack with directed and random words, gives the verdict.
module char_stack_with_occurrence_count_tb;
  import csoc_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int N_PHASE = 8;
  localparam int CYCLE_LIMIT = 1000000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        command = CMD_PUSH;
  logic [BYTE_W-1:0] item_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        status;
  logic [BYTE_W-1:0] popped_byte;
  logic [CNT_W-1:0]  match_count;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CAP_W-1:0]  capacity_in_use = CAP_RESET;

  int fail_count;
  int pending;
  int words_sent = 0;
  int snd_idle = 11;
  int rcv_idle = 56;
  int cycle_count = 0;

  int phase_cap  [N_PHASE] = '{3, 0, 255, 7, 1, 200, 128, 2};
  int phase_len  [N_PHASE] = '{100, 40, 220, 100, 100, 150, 150, 140};
  int phase_push [N_PHASE] = '{50, 60, 90, 35, 55, 70, 60, 50};

  char_stack_with_occurrence_count i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .item_byte(item_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .popped_byte(popped_byte),
    .match_count(match_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .capacity_in_use(capacity_in_use)
  );

  csoc_result_checker u_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .item_byte(item_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .popped_byte(popped_byte),
    .match_count(match_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .capacity_in_use(capacity_in_use),
    .fail_count(fail_count),
    .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < rcv_idle);

  task automatic send_word(input logic [1:0] cmd, input logic [BYTE_W-1:0] chr);
    if (words_sent < 340) begin
      snd_idle = 11;
      rcv_idle = 56;
    end else if (words_sent < 680) begin
      snd_idle = 56;
      rcv_idle = 11;
    end else begin
      snd_idle = 0;
      rcv_idle = 0;
    end
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    item_byte <= chr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // drain all results, then write the capacity register
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    capacity_in_use <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [1:0]        cmd;
    logic [BYTE_W-1:0] chr;
    int                pick;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty stack skips the duplicate check
    send_word(CMD_PUSH, CHAR_LOWER_A);
    send_word(CMD_PUSH, CHAR_LOWER_A);
    send_word(CMD_PUSH, CHAR_LOWER_Z);
    send_word(CMD_PUSH, CHAR_LOWER_A - 8'd1);
    send_word(CMD_PUSH, CHAR_LOWER_Z + 8'd1);
    send_word(CMD_PUSH, 8'h00);
    send_word(CMD_PUSH, 8'hff);
    send_word(CMD_COUNT, CHAR_LOWER_A);
    send_word(CMD_COUNT, 8'hff);
    send_word(CMD_UNUSED, 8'haa);
    send_word(CMD_POP, 8'h55);
    send_word(CMD_POP, 8'h00);
    send_word(CMD_POP, 8'hff);
    send_word(CMD_COUNT, CHAR_LOWER_A);

    // full wins over letter and duplicate checks
    write_capacity(8'd1);
    send_word(CMD_PUSH, CHAR_LOWER_A + 8'd2);
    send_word(CMD_PUSH, 8'h00);
    send_word(CMD_PUSH, CHAR_LOWER_A + 8'd2);
    send_word(CMD_COUNT, CHAR_LOWER_A + 8'd2);

    write_capacity(8'd0);
    send_word(CMD_POP, 8'h00);
    send_word(CMD_PUSH, CHAR_LOWER_A + 8'd16);

    for (int p = 0; p < N_PHASE; p++) begin
      write_capacity(CAP_W'(phase_cap[p]));
      for (int n = 0; n < phase_len[p]; n++) begin
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) chr = BYTE_W'($urandom_range(0, 255));
        else chr = CHAR_LOWER_A + BYTE_W'($urandom_range(0, 25));
        if (pick < phase_push[p]) begin
          cmd = CMD_PUSH;
        end else begin
          pick = $urandom_range(0, 19);
          cmd = (pick < 13) ? CMD_POP : (pick < 19) ? CMD_COUNT : CMD_UNUSED;
        end
        send_word(cmd, chr);
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/csoc_pkg.sv
rtl/csoc_ram.sv
rtl/csoc_match.sv
rtl/char_stack_with_occurrence_count.sv
tb/csoc_result_checker.sv
tb/char_stack_with_occurrence_count_tb.sv
